@@ src/area_average_rgb_downscaler_defines.svh @@
// ----------------------------------------------------------------------------
// area average rgb downscaler assertion macros
// shared property forms for the downscaler checks
// ----------------------------------------------------------------------------
`ifndef AREA_AVERAGE_RGB_DOWNSCALER_DEFINES_SVH
`define AREA_AVERAGE_RGB_DOWNSCALER_DEFINES_SVH

// same-cycle implication
`define AAD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("downscaler assertion failed");

// next-cycle implication
`define AAD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("downscaler assertion failed");

`endif

@@ src/aad_pkg.sv @@
// ----------------------------------------------------------------------------
// aad_pkg
// shared sizes, types and helpers for the area average rgb downscaler
// ----------------------------------------------------------------------------
package aad_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int SIZE_W     = 13;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int PIX_W      = 8;
  localparam int NCH        = 3;
  localparam int SUM_W      = 32;
  localparam int ACC_W      = NCH * SUM_W;
  localparam int AREA_W     = 2 * SIZE_W;
  localparam int QSTEPS     = PIX_W;
  localparam int CNT_W      = $clog2(QSTEPS);
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 2'd3;

  typedef logic [NCH-1:0][SUM_W-1:0] rgb_sum_t;
  typedef logic [NCH-1:0][PIX_W-1:0] rgb_pix_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                  input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ src/aad_ram.sv @@
// ----------------------------------------------------------------------------
// aad_ram
// one write port, one registered read port
// ----------------------------------------------------------------------------
module aad_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/aad_div.sv @@
// ----------------------------------------------------------------------------
// aad_div
// three-channel restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module aad_div (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           start,
  input  aad_pkg::rgb_sum_t                              dividend,
  input  logic [aad_pkg::AREA_W-1:0]                     divisor,
  output logic                                           done,
  output logic [aad_pkg::NCH-1:0][aad_pkg::PIX_W-1:0]    quot
);

  aad_pkg::rgb_sum_t               rem;
  logic [aad_pkg::SUM_W:0]         dsh;
  logic [aad_pkg::CNT_W-1:0]       cnt;
  logic                            busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= aad_pkg::CNT_W'(aad_pkg::QSTEPS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      dsh <= (aad_pkg::SUM_W + 1)'(divisor) << (aad_pkg::QSTEPS - 1);
    end else if (busy) begin
      for (int ch = 0; ch < aad_pkg::NCH; ch++) begin
        if ({1'b0, rem[ch]} >= dsh) begin
          rem[ch]  <= aad_pkg::SUM_W'({1'b0, rem[ch]} - dsh);
          quot[ch] <= {quot[ch][aad_pkg::PIX_W-2:0], 1'b1};
        end else begin
          quot[ch] <= {quot[ch][aad_pkg::PIX_W-2:0], 1'b0};
        end
      end
      dsh <= dsh >> 1;
    end
  end

endmodule

@@ src/area_average_rgb_downscaler.sv @@
// ----------------------------------------------------------------------------
// area_average_rgb_downscaler
// Shrinks a raster-order rgb stream by area averaging. Per-column sums for
// the current and next output line live in two 4096-entry memories that are
// read, updated and written back for each source pixel. A source pixel goes
// through a read of two entries and two write-backs through one write port
// per memory; a pixel that completes an output pixel adds the divide by the
// source area (eight quotient bits and the done flag) and the output load.
// After reset and after every configuration write the memories are swept to
// zero, during which no pixel is taken.
// ----------------------------------------------------------------------------
`include "area_average_rgb_downscaler_defines.svh"

module area_average_rgb_downscaler (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [aad_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [aad_pkg::SIZE_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [aad_pkg::PIX_W-1:0]         red_in,
  input  logic [aad_pkg::PIX_W-1:0]         green_in,
  input  logic [aad_pkg::PIX_W-1:0]         blue_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [aad_pkg::PIX_W-1:0]         red_out,
  output logic [aad_pkg::PIX_W-1:0]         green_out,
  output logic [aad_pkg::PIX_W-1:0]         blue_out,
  output logic [aad_pkg::COL_W-1:0]         out_column,
  output logic [aad_pkg::ROW_W-1:0]         out_line,
  output logic                              frame_end
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_RD1   = 8'b0000_0100,
    S_RD2   = 8'b0000_1000,
    S_WR1   = 8'b0001_0000,
    S_WR0   = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  localparam int PW = aad_pkg::AREA_W + aad_pkg::PIX_W;

  state_t state;

  logic [aad_pkg::SIZE_W-1:0] src_width, src_height, dst_width, dst_height;
  logic [aad_pkg::COL_W-1:0]  column_phase, source_column, output_column, clr_addr;
  logic [aad_pkg::ROW_W-1:0]  row_phase, output_row;
  logic [aad_pkg::AREA_W-1:0] area;

  logic [aad_pkg::SIZE_W-1:0] sw, sh, dw0, dh0, dw, dh;
  logic [aad_pkg::SIZE_W:0]   cs, rs;
  logic                       cross_col, cross_row, col_done, row_done;
  logic [aad_pkg::SIZE_W-1:0] wx0_c, wx1_c, wy0_c, wy1_c, sc1;
  logic                       has1_c, fe_c;

  aad_pkg::rgb_pix_t          pix;
  logic [aad_pkg::COL_W-1:0]  ox;
  logic [aad_pkg::ROW_W-1:0]  line_q;
  logic                       fe_q, emit_q, has1_q, xrow_q;
  logic [aad_pkg::SIZE_W-1:0] wx0, wx1, wy0, wy1;
  logic [aad_pkg::AREA_W-1:0] w00, w10, w01, w11;
  aad_pkg::rgb_sum_t          p00, p10, p01, p11, cur0, nxt0, cur1, nxt1;
  aad_pkg::rgb_sum_t          cur_sum0, nxt_sum0;

  logic                       cur_we, nxt_we;
  logic [aad_pkg::COL_W-1:0]  waddr, raddr;
  aad_pkg::rgb_sum_t          cur_wd, nxt_wd, cur_rd, nxt_rd;

  logic                       div_start, div_done;
  logic [aad_pkg::NCH-1:0][aad_pkg::PIX_W-1:0] quot;
  logic                       cfg_hit, out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign cfg_hit   = cfg_valid && cfg_ready;
  assign out_load  = (state == S_OUT) && (!out_valid || out_ready);

  // effective sizes and weights
  always_comb begin
    sw  = aad_pkg::clamp_size(src_width, aad_pkg::SIZE_W'(aad_pkg::MAX_WIDTH));
    sh  = aad_pkg::clamp_size(src_height, aad_pkg::SIZE_W'(aad_pkg::MAX_HEIGHT));
    dw0 = aad_pkg::clamp_size(dst_width, aad_pkg::SIZE_W'(aad_pkg::MAX_WIDTH));
    dh0 = aad_pkg::clamp_size(dst_height, aad_pkg::SIZE_W'(aad_pkg::MAX_HEIGHT));
    dw  = (dw0 > sw) ? sw : dw0;
    dh  = (dh0 > sh) ? sh : dh0;

    cs        = (aad_pkg::SIZE_W + 1)'(column_phase) + (aad_pkg::SIZE_W + 1)'(dw);
    cross_col = cs > (aad_pkg::SIZE_W + 1)'(sw);
    col_done  = cs >= (aad_pkg::SIZE_W + 1)'(sw);
    wx0_c     = cross_col ? (sw - aad_pkg::SIZE_W'(column_phase)) : dw;
    wx1_c     = cross_col ? aad_pkg::SIZE_W'(cs - (aad_pkg::SIZE_W + 1)'(sw)) : '0;

    rs        = (aad_pkg::SIZE_W + 1)'(row_phase) + (aad_pkg::SIZE_W + 1)'(dh);
    cross_row = rs > (aad_pkg::SIZE_W + 1)'(sh);
    row_done  = rs >= (aad_pkg::SIZE_W + 1)'(sh);
    wy0_c     = cross_row ? (sh - aad_pkg::SIZE_W'(row_phase)) : dh;
    wy1_c     = cross_row ? aad_pkg::SIZE_W'(rs - (aad_pkg::SIZE_W + 1)'(sh)) : '0;

    has1_c = cross_col && ((aad_pkg::SIZE_W'(output_column) + 1'b1) < dw);
    fe_c   = ((aad_pkg::SIZE_W'(output_row) + 1'b1) >= dh) &&
             ((aad_pkg::SIZE_W'(output_column) + 1'b1) >= dw);
    sc1    = aad_pkg::SIZE_W'(source_column) + 1'b1;
  end

  // control and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      src_width     <= aad_pkg::SIZE_W'(1);
      src_height    <= aad_pkg::SIZE_W'(1);
      dst_width     <= aad_pkg::SIZE_W'(1);
      dst_height    <= aad_pkg::SIZE_W'(1);
      column_phase  <= '0;
      row_phase     <= '0;
      source_column <= '0;
      output_column <= '0;
      output_row    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_hit) begin
        case (cfg_index)
          aad_pkg::CFG_SRC_WIDTH:  src_width  <= cfg_data;
          aad_pkg::CFG_SRC_HEIGHT: src_height <= cfg_data;
          aad_pkg::CFG_DST_WIDTH:  dst_width  <= cfg_data;
          aad_pkg::CFG_DST_HEIGHT: dst_height <= cfg_data;
          default: ;
        endcase
        state         <= S_CLEAR;
        clr_addr      <= '0;
        column_phase  <= '0;
        row_phase     <= '0;
        source_column <= '0;
        output_column <= '0;
        output_row    <= '0;
      end else begin
        case (state)
          S_CLEAR: begin
            clr_addr <= clr_addr + 1'b1;
            if (&clr_addr) begin
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (in_valid) begin
              state <= S_RD1;
              if (sc1 >= sw) begin
                source_column <= '0;
                column_phase  <= '0;
                output_column <= '0;
                if (row_done) begin
                  if ((aad_pkg::SIZE_W'(output_row) + 1'b1) >= dh) begin
                    row_phase  <= '0;
                    output_row <= '0;
                  end else begin
                    row_phase  <= aad_pkg::ROW_W'(rs - (aad_pkg::SIZE_W + 1)'(sh));
                    output_row <= output_row + 1'b1;
                  end
                end else begin
                  row_phase <= aad_pkg::ROW_W'(rs);
                end
              end else begin
                source_column <= aad_pkg::COL_W'(sc1);
                if (col_done) begin
                  column_phase  <= aad_pkg::COL_W'(cs - (aad_pkg::SIZE_W + 1)'(sw));
                  output_column <= output_column + 1'b1;
                end else begin
                  column_phase <= aad_pkg::COL_W'(cs);
                end
              end
            end
          end
          S_RD1: state <= S_RD2;
          S_RD2: state <= S_WR1;
          S_WR1: state <= S_WR0;
          S_WR0: state <= emit_q ? S_DIV : S_IDLE;
          S_DIV: begin
            if (div_done) begin
              state <= S_OUT;
            end
          end
          S_OUT: begin
            if (out_load) begin
              state <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    area <= aad_pkg::AREA_W'(sw) * aad_pkg::AREA_W'(sh);
    if (in_valid && in_ready) begin
      pix    <= {blue_in, green_in, red_in};
      ox     <= output_column;
      line_q <= output_row;
      fe_q   <= fe_c;
      emit_q <= col_done && row_done;
      has1_q <= has1_c;
      xrow_q <= cross_row;
      wx0    <= wx0_c;
      wx1    <= wx1_c;
      wy0    <= wy0_c;
      wy1    <= wy1_c;
    end
    if (state == S_RD1) begin
      cur0 <= cur_rd;
      nxt0 <= nxt_rd;
      w00  <= aad_pkg::AREA_W'(wx0) * aad_pkg::AREA_W'(wy0);
      w10  <= aad_pkg::AREA_W'(wx1) * aad_pkg::AREA_W'(wy0);
      w01  <= aad_pkg::AREA_W'(wx0) * aad_pkg::AREA_W'(wy1);
      w11  <= aad_pkg::AREA_W'(wx1) * aad_pkg::AREA_W'(wy1);
    end
    if (state == S_RD2) begin
      cur1 <= cur_rd;
      nxt1 <= nxt_rd;
      for (int ch = 0; ch < aad_pkg::NCH; ch++) begin
        p00[ch] <= aad_pkg::SUM_W'(PW'(w00) * PW'(pix[ch]));
        p10[ch] <= aad_pkg::SUM_W'(PW'(w10) * PW'(pix[ch]));
        p01[ch] <= aad_pkg::SUM_W'(PW'(w01) * PW'(pix[ch]));
        p11[ch] <= aad_pkg::SUM_W'(PW'(w11) * PW'(pix[ch]));
      end
    end
    if (out_load) begin
      red_out    <= quot[0];
      green_out  <= quot[1];
      blue_out   <= quot[2];
      out_column <= ox;
      out_line   <= line_q;
      frame_end  <= fe_q;
    end
  end

  // memory port control
  always_comb begin
    raddr  = (state == S_IDLE) ? output_column : (ox + 1'b1);
    cur_we = 1'b0;
    nxt_we = 1'b0;
    waddr  = ox;
    for (int ch = 0; ch < aad_pkg::NCH; ch++) begin
      cur_sum0[ch] = cur0[ch] + p00[ch];
      nxt_sum0[ch] = nxt0[ch] + p01[ch];
      cur_wd[ch]   = '0;
      nxt_wd[ch]   = '0;
    end
    case (state)
      S_CLEAR: begin
        cur_we = 1'b1;
        nxt_we = 1'b1;
        waddr  = clr_addr;
      end
      S_WR1: begin
        cur_we = has1_q;
        nxt_we = has1_q && xrow_q;
        waddr  = ox + 1'b1;
        for (int ch = 0; ch < aad_pkg::NCH; ch++) begin
          cur_wd[ch] = cur1[ch] + p10[ch];
          nxt_wd[ch] = nxt1[ch] + p11[ch];
        end
      end
      S_WR0: begin
        cur_we = 1'b1;
        nxt_we = 1'b1;
        cur_wd = emit_q ? nxt_sum0 : cur_sum0;
        nxt_wd = emit_q ? '0 : nxt_sum0;
      end
      default: ;
    endcase
  end

  assign div_start = (state == S_WR0) && emit_q;

  aad_ram #(.WIDTH(aad_pkg::ACC_W), .DEPTH(aad_pkg::MAX_WIDTH)) u_cur_ram (
    .clk   (clk),
    .we    (cur_we),
    .waddr (waddr),
    .wdata (cur_wd),
    .raddr (raddr),
    .rdata (cur_rd)
  );

  aad_ram #(.WIDTH(aad_pkg::ACC_W), .DEPTH(aad_pkg::MAX_WIDTH)) u_nxt_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (waddr),
    .wdata (nxt_wd),
    .raddr (raddr),
    .rdata (nxt_rd)
  );

  aad_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cur_sum0),
    .divisor  (area),
    .done     (div_done),
    .quot     (quot)
  );

  `AAD_ASSERT_NEXT(a_one_word_at_a_time, in_valid && in_ready, !in_ready)
  `AAD_ASSERT_NEXT(a_cfg_starts_clear, cfg_valid && cfg_ready, state == S_CLEAR)
  `AAD_ASSERT_NEXT(a_out_only_from_load, !out_valid && state != S_OUT, !out_valid)
  `AAD_ASSERT_IMPL(a_no_write_while_dividing, state == S_DIV, !cur_we && !nxt_we)

endmodule
